/* design/ssfb_pkg.sv */
package ssfb_pkg;

	typedef struct packed {
		logic [15:0]        speed;
		logic [15:0]        rcf;
		logic signed [15:0] temperature;
		logic               show_rcf;
		logic               run_lamp;
		logic               stop_lamp;
	} refresh_req_t;

	typedef struct packed {
		logic [7:0] frame_byte;
		logic       is_command;
		logic       last;
	} frame_req_t;

	// quotients of the shown value and of the temperature magnitude
	typedef struct packed {
		logic [15:0] v;
		logic [12:0] q1;
		logic [9:0]  q2;
		logic [6:0]  q3;
		logic [2:0]  q4;
		logic        show_rcf;
		logic        run_lamp;
		logic        stop_lamp;
		logic        oor;
		logic        neg;
		logic [10:0] m;
		logic [6:0]  tq1;
		logic [3:0]  tq2;
	} quot_t;

	typedef struct packed {
		logic [7:0][7:0] grid;
		logic            run_lamp;
		logic            stop_lamp;
	} frame_t;

	localparam logic [7:0] GLYPH_BLANK = 8'h00;
	localparam logic [7:0] GLYPH_MINUS = 8'h40;
	localparam logic [7:0] SEG_DOT     = 8'h80;
	localparam logic [7:0] LAMP_ON     = 8'h01;

	localparam logic [7:0] CMD_MODE = 8'h03;
	localparam logic [7:0] CMD_AUTO = 8'h40;
	localparam logic [7:0] CMD_ADDR = 8'hC0;
	localparam logic [7:0] CMD_DISP = 8'h8C;

	localparam logic [4:0] CNT_MODE  = 5'd0;
	localparam logic [4:0] CNT_AUTO  = 5'd1;
	localparam logic [4:0] CNT_ADDR  = 5'd2;
	localparam logic [4:0] CNT_FIRST = 5'd3;
	localparam logic [4:0] CNT_DISP  = 5'd19;

	// reciprocal multiplies, exact over the full 16-bit range
	function automatic logic [12:0] div10(input logic [15:0] x);
		logic [32:0] p;
		p = 33'(x) * 33'd52429;
		return p[31:19];
	endfunction

	function automatic logic [9:0] div100(input logic [15:0] x);
		logic [32:0] p;
		p = 33'(x) * 33'd83887;
		return p[32:23];
	endfunction

	function automatic logic [6:0] div1000(input logic [15:0] x);
		logic [32:0] p;
		p = 33'(x) * 33'd67109;
		return p[32:26];
	endfunction

	function automatic logic [2:0] div10000(input logic [15:0] x);
		logic [32:0] p;
		p = 33'(x) * 33'd107375;
		return p[32:30];
	endfunction

	// x - 10*q where q = x/10
	function automatic logic [3:0] rem10(input logic [15:0] x, input logic [15:0] q);
		logic [15:0] r;
		r = x - ((q << 3) + (q << 1));
		return r[3:0];
	endfunction

	function automatic logic [7:0] seg_of(input logic [3:0] d);
		logic [7:0] s;
		case (d)
			4'd0: s = 8'h3f;
			4'd1: s = 8'h06;
			4'd2: s = 8'h5b;
			4'd3: s = 8'h4f;
			4'd4: s = 8'h66;
			4'd5: s = 8'h6d;
			4'd6: s = 8'h7d;
			4'd7: s = 8'h07;
			4'd8: s = 8'h7f;
			4'd9: s = 8'h6f;
			default: s = GLYPH_BLANK;
		endcase
		return s;
	endfunction

endpackage

/* design/seven_segment_status_frame_builder.sv */
// channel  | dir | handshake                      | payload
// refresh  | in  | refresh_valid / refresh_stall  | refresh_req_t: speed, rcf, temperature, lamps
// frame    | out | frame_valid / frame_stall      | frame_req_t: frame_byte, is_command, last
//
// One refresh request yields twenty frame requests, one per cycle when the
// sink does not stall; the byte serializer sets that rate.
// Path from refresh accept to first byte: input reg, quotient reg, frame load.
// The next refresh is taken in while the current frame drains.
// Reset clears all valid flags, the byte counter and the temperature dot flag.
// A stalled frame byte holds; the stall backs up through both pipeline stages.
module seven_segment_status_frame_builder import ssfb_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         refresh_valid,
	output logic         refresh_stall,
	input  refresh_req_t refresh_data,
	output logic         frame_valid,
	input  logic         frame_stall,
	output frame_req_t   frame_data
);

	// quotient stage: divides by 10/100/1000/10000 via reciprocal multiplies
	logic   quot_valid;
	logic   load;
	quot_t  quot;

	// glyph logic: digits, blanking, temperature rules, dots, transpose
	frame_t frame_next;
	logic   dot_flag;
	logic   dot_flag_next;

	ssfb_quot u_quot (
		.clk           (clk),
		.arst_n        (arst_n),
		.refresh_valid (refresh_valid),
		.refresh_stall (refresh_stall),
		.refresh_data  (refresh_data),
		.quot_valid    (quot_valid),
		.quot_take     (load),
		.quot          (quot)
	);

	// dot flag is the state carried between refreshes; it updates at frame load,
	// in request order, so the next refresh sees the flag this one leaves
	ssfb_glyph u_glyph (
		.quot          (quot),
		.dot_flag      (dot_flag),
		.frame         (frame_next),
		.dot_flag_next (dot_flag_next)
	);

	// frame register and byte counter: commands, grid/lamp pairs, closing command
	ssfb_serial u_serial (
		.clk           (clk),
		.arst_n        (arst_n),
		.load_valid    (quot_valid),
		.load          (load),
		.frame_in      (frame_next),
		.dot_flag_next (dot_flag_next),
		.dot_flag      (dot_flag),
		.frame_valid   (frame_valid),
		.frame_stall   (frame_stall),
		.frame_data    (frame_data)
	);

endmodule

/* design/ssfb_quot.sv */
module ssfb_quot import ssfb_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         refresh_valid,
	output logic         refresh_stall,
	input  refresh_req_t refresh_data,
	output logic         quot_valid,
	input  logic         quot_take,
	output quot_t        quot
);

	logic         valid_s1;
	refresh_req_t data_s1;
	logic         valid_s2;
	quot_t        quot_s2;
	logic         adv1, adv2;
	quot_t        quot_d;
	logic [15:0]  v;
	logic [15:0]  tm;
	logic [15:0]  m16;

	assign adv2 = !valid_s2 || quot_take;
	assign adv1 = !valid_s1 || adv2;
	assign refresh_stall = !adv1;

	always_comb begin
		v   = data_s1.show_rcf ? data_s1.rcf : data_s1.speed;
		tm  = data_s1.temperature[15] ? 16'(-data_s1.temperature) : data_s1.temperature;
		m16 = {5'd0, tm[10:0]};
		quot_d.v         = v;
		quot_d.q1        = div10(v);
		quot_d.q2        = div100(v);
		quot_d.q3        = div1000(v);
		quot_d.q4        = div10000(v);
		quot_d.show_rcf  = data_s1.show_rcf;
		quot_d.run_lamp  = data_s1.run_lamp;
		quot_d.stop_lamp = data_s1.stop_lamp;
		quot_d.oor       = (data_s1.temperature <= -16'sd260) ||
		                   (data_s1.temperature >= 16'sd1100);
		quot_d.neg       = data_s1.temperature[15];
		quot_d.m         = tm[10:0];
		quot_d.tq1       = 7'(div10(m16));
		quot_d.tq2       = 4'(div100(m16));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (adv1)
				valid_s1 <= refresh_valid;
			if (adv2)
				valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv1 && refresh_valid)
			data_s1 <= refresh_data;
		if (adv2 && valid_s1)
			quot_s2 <= quot_d;
	end

	assign quot_valid = valid_s2;
	assign quot       = quot_s2;

endmodule

/* design/ssfb_glyph.sv */
module ssfb_glyph import ssfb_pkg::*; (
	input  quot_t  quot,
	input  logic   dot_flag,
	output frame_t frame,
	output logic   dot_flag_next
);

	logic [7:0][7:0] seg;
	logic [3:0]      dig0, dig1, dig2, dig3, dig4;
	logic [3:0]      t_u, t_te, t_h;
	logic            flag;

	always_comb begin
		dig4 = rem10(quot.v, 16'(quot.q1));
		dig3 = rem10(16'(quot.q1), 16'(quot.q2));
		dig2 = rem10(16'(quot.q2), 16'(quot.q3));
		dig1 = rem10(16'(quot.q3), 16'(quot.q4));
		dig0 = 4'(quot.q4);

		// leading blanks: value below 10^(4-d) means the quotient is zero
		seg[0] = (quot.q4 == '0) ? GLYPH_BLANK : seg_of(dig0);
		seg[1] = (quot.q3 == '0) ? GLYPH_BLANK : seg_of(dig1);
		seg[2] = (quot.q2 == '0) ? GLYPH_BLANK : seg_of(dig2);
		seg[3] = (quot.q1 == '0) ? GLYPH_BLANK : seg_of(dig3);
		seg[4] = seg_of(dig4) | (quot.show_rcf ? SEG_DOT : GLYPH_BLANK);

		t_u  = rem10(16'(quot.m), 16'(quot.tq1));
		t_te = rem10(16'(quot.tq1), 16'(quot.tq2));
		t_h  = (quot.tq2 >= 4'd10) ? quot.tq2 - 4'd10 : quot.tq2;

		flag = dot_flag;
		if (quot.oor) begin
			seg[5] = GLYPH_MINUS;
			seg[6] = GLYPH_MINUS;
			seg[7] = GLYPH_MINUS;
		end else if (!quot.neg) begin
			seg[5] = (quot.m < 11'd100) ? GLYPH_BLANK : seg_of(t_h);
			seg[6] = seg_of(t_te);
			seg[7] = seg_of(t_u);
			flag   = 1'b1;
		end else if (quot.m > 11'd100) begin
			// units dropped, no decimal point
			seg[5] = GLYPH_MINUS;
			seg[6] = seg_of(t_h);
			seg[7] = seg_of(t_te);
			flag   = 1'b0;
		end else begin
			seg[5] = GLYPH_MINUS;
			seg[6] = seg_of(t_te);
			seg[7] = seg_of(t_u);
			flag   = 1'b1;
		end
		if (flag)
			seg[6] = seg[6] | SEG_DOT;

		for (int g = 0; g < 8; g++) begin
			for (int d = 0; d < 8; d++) begin
				frame.grid[g][d] = seg[d][g];
			end
		end
		frame.run_lamp  = quot.run_lamp;
		frame.stop_lamp = quot.stop_lamp;
		dot_flag_next   = flag;
	end

endmodule

/* design/ssfb_serial.sv */
module ssfb_serial import ssfb_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       load_valid,
	output logic       load,
	input  frame_t     frame_in,
	input  logic       dot_flag_next,
	output logic       dot_flag,
	output logic       frame_valid,
	input  logic       frame_stall,
	output frame_req_t frame_data
);

	logic       busy_q;
	logic [4:0] cnt_q;
	frame_t     frame_q;
	logic       dot_q;
	logic       done;
	logic [4:0] idx;
	logic [2:0] g;

	assign done = busy_q && !frame_stall && (cnt_q == CNT_DISP);
	assign load = load_valid && (!busy_q || done);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= CNT_MODE;
			dot_q  <= 1'b0;
		end else if (load) begin
			busy_q <= 1'b1;
			cnt_q  <= CNT_MODE;
			dot_q  <= dot_flag_next;
		end else if (busy_q && !frame_stall) begin
			if (cnt_q == CNT_DISP)
				busy_q <= 1'b0;
			else
				cnt_q <= cnt_q + 5'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (load)
			frame_q <= frame_in;
	end

	always_comb begin
		idx = cnt_q - CNT_FIRST;
		g   = idx[3:1];
		frame_data.is_command = 1'b0;
		frame_data.last       = 1'b0;
		case (cnt_q)
			CNT_MODE: begin
				frame_data.frame_byte = CMD_MODE;
				frame_data.is_command = 1'b1;
			end
			CNT_AUTO: begin
				frame_data.frame_byte = CMD_AUTO;
				frame_data.is_command = 1'b1;
			end
			CNT_ADDR: begin
				frame_data.frame_byte = CMD_ADDR;
				frame_data.is_command = 1'b1;
			end
			CNT_DISP: begin
				frame_data.frame_byte = CMD_DISP;
				frame_data.is_command = 1'b1;
				frame_data.last       = 1'b1;
			end
			default: begin
				if (!idx[0])
					frame_data.frame_byte = frame_q.grid[g];
				else if ((g == 3'd0 && frame_q.run_lamp) || (g == 3'd1 && frame_q.stop_lamp))
					frame_data.frame_byte = LAMP_ON;
				else
					frame_data.frame_byte = GLYPH_BLANK;
			end
		endcase
	end

	assign frame_valid = busy_q;
	assign dot_flag    = dot_q;

endmodule

/* dv/seven_segment_status_frame_builder_tb.sv */
`timescale 1ns / 1ps

// Refresh requests go in on one channel; each comes back as a twenty-byte
// display frame. A local frame predictor builds the expected bytes when a
// refresh request is accepted, and the frame checker pops them in order.
module seven_segment_status_frame_builder_tb;
	import ssfb_pkg::*;

	// temperature window, in tenths of a degree; at or beyond its limits the display shows dashes
	localparam int TEMP_LOW  = -260;
	localparam int TEMP_HIGH = 1100;
	// cycles with no accepted request on either channel before the run is abandoned
	localparam int WATCHDOG_LIMIT = 2000;
	// drain time after the last expected byte
	localparam int DRAIN_CYCLES = 20;
	localparam int RANDOM_REFRESHES = 452;
	localparam int MAX_PRINTED = 50;

	logic         clk = 1'b0;
	logic         arst_n = 1'b0;
	logic         refresh_valid = 1'b0;
	logic         refresh_stall;
	refresh_req_t refresh_data = '0;
	logic         frame_valid;
	logic         frame_stall = 1'b0;
	frame_req_t   frame_data;

	refresh_req_t refresh_pending[$];   // requests not yet presented
	frame_req_t   frame_expected[$];    // predicted bytes not yet seen
	logic         dot_on = 1'b0;        // predictor copy of the temperature dot
	logic         refresh_taken = 1'b0; // last posedge accepted a refresh
	int           total_refreshes = 0;
	int           refreshes_sent = 0;
	int           refreshes_accepted = 0;
	int           bytes_seen = 0;
	int           mismatches = 0;
	int           quiet_cycles = 0;

	seven_segment_status_frame_builder dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.refresh_valid(refresh_valid),
		.refresh_stall(refresh_stall),
		.refresh_data (refresh_data),
		.frame_valid  (frame_valid),
		.frame_stall  (frame_stall),
		.frame_data   (frame_data)
	);

	initial begin
		forever #1 clk = ~clk;
	end

	function automatic logic [7:0] glyph(input int unsigned digit);
		logic [7:0] s;
		case (digit)
			0: s = 8'h3f;
			1: s = 8'h06;
			2: s = 8'h5b;
			3: s = 8'h4f;
			4: s = 8'h66;
			5: s = 8'h6d;
			6: s = 8'h7d;
			7: s = 8'h07;
			8: s = 8'h7f;
			9: s = 8'h6f;
			default: s = GLYPH_BLANK;
		endcase
		return s;
	endfunction

	task automatic push_byte(input logic [7:0] value, input logic cmd, input logic closing);
		frame_req_t b;
		b.frame_byte = value;
		b.is_command = cmd;
		b.last       = closing;
		frame_expected.push_back(b);
	endtask

	// Builds the twenty bytes one refresh produces and updates the dot flag.
	task automatic predict_frame(input refresh_req_t r);
		logic [7:0]  seg [8];
		logic [7:0]  grid;
		logic [7:0]  lamp;
		int unsigned shown;
		int unsigned scale;
		int unsigned mag;
		int          t;
		shown = r.show_rcf ? r.rcf : r.speed;
		scale = 1;
		for (int d = 4; d >= 0; d--) begin
			seg[d] = glyph((shown / scale) % 10);
			// leading zeros blanked on digits 0-3 only
			if (d < 4 && shown < scale)
				seg[d] = GLYPH_BLANK;
			scale = scale * 10;
		end

		t = $signed(r.temperature);
		if (t <= TEMP_LOW || t >= TEMP_HIGH) begin
			// dashes, dot flag untouched
			seg[5] = GLYPH_MINUS;
			seg[6] = GLYPH_MINUS;
			seg[7] = GLYPH_MINUS;
		end else if (t >= 0) begin
			mag = t;
			seg[7] = glyph(mag % 10);
			seg[6] = glyph((mag / 10) % 10);
			seg[5] = (mag < 100) ? GLYPH_BLANK : glyph((mag / 100) % 10);
			dot_on = 1'b1;
		end else begin
			mag = -t;
			seg[5] = GLYPH_MINUS;
			if (mag > 100) begin
				// units dropped, dot cleared
				seg[6] = glyph((mag / 100) % 10);
				seg[7] = glyph((mag / 10) % 10);
				dot_on = 1'b0;
			end else begin
				seg[6] = glyph((mag / 10) % 10);
				seg[7] = glyph(mag % 10);
				dot_on = 1'b1;
			end
		end

		if (r.show_rcf)
			seg[4] = seg[4] | SEG_DOT;
		if (dot_on)
			seg[6] = seg[6] | SEG_DOT;

		push_byte(CMD_MODE, 1'b1, 1'b0);
		push_byte(CMD_AUTO, 1'b1, 1'b0);
		push_byte(CMD_ADDR, 1'b1, 1'b0);
		for (int g = 0; g < 8; g++) begin
			// transpose: grid byte g carries segment bit g of every digit
			for (int d = 0; d < 8; d++)
				grid[d] = seg[d][g];
			lamp = GLYPH_BLANK;
			if (g == 0 && r.run_lamp)
				lamp = LAMP_ON;
			if (g == 1 && r.stop_lamp)
				lamp = LAMP_ON;
			push_byte(grid, 1'b0, 1'b0);
			push_byte(lamp, 1'b0, 1'b0);
		end
		push_byte(CMD_DISP, 1'b1, 1'b1);
	endtask

	task automatic report_mismatch(input string what, input int got, input int want);
		if (mismatches < MAX_PRINTED)
			$display("%0t ns: frame byte %0d: %s got 0x%0h want 0x%0h",
				$realtime, bytes_seen, what, got, want);
		mismatches++;
	endtask

	function automatic refresh_req_t make_refresh(input int unsigned spd, input int unsigned frc,
			input int temp, input logic show, input logic run, input logic stop);
		refresh_req_t r;
		r.speed       = spd[15:0];
		r.rcf         = frc[15:0];
		r.temperature = temp[15:0];
		r.show_rcf    = show;
		r.run_lamp    = run;
		r.stop_lamp   = stop;
		return r;
	endfunction

	// Shown values spread over every digit count so the blanking is exercised.
	function automatic int unsigned random_magnitude();
		int unsigned digits;
		digits = $urandom_range(4, 0);
		case (digits)
			0: return $urandom_range(9, 0);
			1: return $urandom_range(99, 0);
			2: return $urandom_range(999, 0);
			3: return $urandom_range(9999, 0);
			default: return $urandom_range(65535, 0);
		endcase
	endfunction

	function automatic int random_temperature();
		int kind;
		int edges [15];
		edges = '{-261, -260, -259, -101, -100, -99, -1, 0, 99, 100, 999, 1000, 1099, 1100, 1101};
		kind = $urandom_range(9, 0);
		if (kind <= 3)
			return $urandom_range(1099, 0);
		else if (kind <= 6)
			return -int'($urandom_range(259, 1));
		else if (kind == 7)
			return edges[$urandom_range(14, 0)];
		else if (kind == 8)
			return ($urandom_range(1, 0) == 1) ? int'($urandom_range(32767, 1100))
				: -int'($urandom_range(32768, 260));
		else
			return $signed(16'($urandom_range(65535, 0)));
	endfunction

	// Idling plan over the run: sender-light then receiver-light, then flat out.
	function automatic int send_idle_pct();
		int phase;
		phase = (total_refreshes == 0) ? 0 : refreshes_sent * 3 / total_refreshes;
		return (phase == 0) ? 31 : (phase == 1) ? 53 : 0;
	endfunction

	function automatic int frame_stall_pct();
		int phase;
		phase = (total_refreshes == 0) ? 0 : refreshes_sent * 3 / total_refreshes;
		return (phase == 0) ? 53 : (phase == 1) ? 31 : 0;
	endfunction

	// Refresh driver: changes inputs at the falling edge, holds a stalled request.
	always @(negedge clk) begin : refresh_drive
		logic         nxt_valid;
		refresh_req_t nxt_data;
		nxt_valid = refresh_valid;
		nxt_data  = refresh_data;
		if (arst_n && (!refresh_valid || refresh_taken)) begin
			nxt_valid = 1'b0;
			if (refresh_pending.size() > 0 && $urandom_range(99, 0) >= send_idle_pct()) begin
				nxt_valid = 1'b1;
				nxt_data  = refresh_pending.pop_front();
				refreshes_sent++;
			end
		end
		refresh_valid <= nxt_valid;
		refresh_data  <= nxt_data;
		frame_stall   <= ($urandom_range(99, 0) < frame_stall_pct());
	end

	// Accept side and frame checker, sampled at the rising edge.
	always @(posedge clk) begin : frame_check
		frame_req_t want;
		if (arst_n) begin
			refresh_taken <= refresh_valid && !refresh_stall;
			if (refresh_valid && !refresh_stall) begin
				predict_frame(refresh_data);
				refreshes_accepted++;
			end
			if (frame_valid && !frame_stall) begin
				if (frame_expected.size() == 0) begin
					report_mismatch("unexpected byte", frame_data.frame_byte, 0);
				end else begin
					want = frame_expected.pop_front();
					if (frame_data.frame_byte !== want.frame_byte)
						report_mismatch("frame_byte", frame_data.frame_byte, want.frame_byte);
					if (frame_data.is_command !== want.is_command)
						report_mismatch("is_command", frame_data.is_command, want.is_command);
					if (frame_data.last !== want.last)
						report_mismatch("last", frame_data.last, want.last);
				end
				bytes_seen++;
			end
		end
	end

	// Watchdog: a stretch with no handshake on either channel that reaches the limit ends the run.
	always @(posedge clk) begin
		if (arst_n) begin
			if ((refresh_valid && !refresh_stall) || (frame_valid && !frame_stall))
				quiet_cycles <= 0;
			else
				quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= WATCHDOG_LIMIT) begin
				$display("status: fail");
				$finish;
			end
		end
	end

	initial begin
		// directed: field extremes, blanking thresholds, every temperature case,
		// and the dot flag carried across out-of-range readings
		refresh_pending.push_back(make_refresh(0, 0, 0, 1'b0, 1'b0, 1'b0));
		refresh_pending.push_back(make_refresh(65535, 0, 1099, 1'b0, 1'b1, 1'b0));
		refresh_pending.push_back(make_refresh(0, 65535, -1, 1'b1, 1'b0, 1'b1));
		refresh_pending.push_back(make_refresh(9, 0, 99, 1'b0, 1'b0, 1'b0));
		refresh_pending.push_back(make_refresh(10, 0, 100, 1'b0, 1'b1, 1'b1));
		refresh_pending.push_back(make_refresh(99, 0, 999, 1'b0, 1'b0, 1'b0));
		refresh_pending.push_back(make_refresh(100, 0, 1000, 1'b0, 1'b0, 1'b0));
		refresh_pending.push_back(make_refresh(999, 0, -100, 1'b0, 1'b0, 1'b0));
		refresh_pending.push_back(make_refresh(1000, 0, -101, 1'b0, 1'b0, 1'b0));
		refresh_pending.push_back(make_refresh(9999, 0, 1100, 1'b0, 1'b0, 1'b0));
		refresh_pending.push_back(make_refresh(10000, 0, -259, 1'b0, 1'b0, 1'b0));
		refresh_pending.push_back(make_refresh(0, 12345, -260, 1'b1, 1'b0, 1'b0));
		refresh_pending.push_back(make_refresh(0, 9, 32767, 1'b1, 1'b0, 1'b0));
		refresh_pending.push_back(make_refresh(0, 10000, 5, 1'b1, 1'b1, 1'b0));
		refresh_pending.push_back(make_refresh(43210, 0, -32768, 1'b0, 1'b0, 1'b1));
		refresh_pending.push_back(make_refresh(1, 1, -260, 1'b0, 1'b0, 1'b0));
		refresh_pending.push_back(make_refresh(65535, 0, 1101, 1'b1, 1'b1, 1'b1));
		refresh_pending.push_back(make_refresh(12, 99999, -99, 1'b0, 1'b1, 1'b1));
		for (int i = 0; i < RANDOM_REFRESHES; i++)
			refresh_pending.push_back(make_refresh($urandom_range(65535, 0) & 16'hffff
				& ((i % 3 == 0) ? 32'hffff : 32'h0) | ((i % 3 == 0) ? 0 : random_magnitude()),
				random_magnitude(), random_temperature(), $urandom_range(1, 0),
				$urandom_range(1, 0), $urandom_range(1, 0)));
		total_refreshes = refresh_pending.size();

		repeat (10) @(negedge clk);
		arst_n <= 1'b1;

		// all refreshes taken and every predicted byte seen
		while (refreshes_accepted < total_refreshes || frame_expected.size() > 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);

		if (mismatches == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule

/* sim.f */
design/ssfb_pkg.sv
design/ssfb_quot.sv
design/ssfb_glyph.sv
design/ssfb_serial.sv
design/seven_segment_status_frame_builder.sv
dv/seven_segment_status_frame_builder_tb.sv
